// ----- rtl/scs1a_pkg.sv -----
// Shared types, scan code constants and key tables for the set 1 translator.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package scs1a_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] KEYMAP_LEN = 8'd58;

  // Scan codes
  localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
  localparam logic [6:0] SC_CTRL       = 7'h1D;
  localparam logic [6:0] SC_LSHIFT     = 7'h2A;
  localparam logic [6:0] SC_RSHIFT     = 7'h36;
  localparam logic [6:0] SC_ALT        = 7'h38;
  localparam logic [6:0] SC_KEY_D      = 7'h20;
  localparam logic [6:0] SC_E_UP       = 7'h48;
  localparam logic [6:0] SC_E_DOWN     = 7'h50;
  localparam logic [6:0] SC_E_LEFT     = 7'h4B;
  localparam logic [6:0] SC_E_RIGHT    = 7'h4D;
  localparam logic [6:0] SC_E_HOME     = 7'h47;
  localparam logic [6:0] SC_E_END      = 7'h4F;
  localparam logic [6:0] SC_E_PRTSC    = 7'h37;

  // Output characters
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_CTRL_D   = 8'h04;
  localparam logic [7:0] CTRL_MASK   = 8'h1F;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_RIGHT    = 8'h43;
  localparam logic [7:0] CH_LEFT     = 8'h44;
  localparam logic [7:0] CH_END      = 8'h46;
  localparam logic [7:0] CH_HOME     = 8'h48;
  localparam logic [7:0] CH_PRTSC    = 8'h70;

  // One queued run of output bytes; cnt is 1..3, bytes go out b0 first
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  function automatic logic [7:0] plain_map(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd1:  ch = 8'h1B;  6'd2:  ch = 8'h31;  6'd3:  ch = 8'h32;  6'd4:  ch = 8'h33;
      6'd5:  ch = 8'h34;  6'd6:  ch = 8'h35;  6'd7:  ch = 8'h36;  6'd8:  ch = 8'h37;
      6'd9:  ch = 8'h38;  6'd10: ch = 8'h39;  6'd11: ch = 8'h30;  6'd12: ch = 8'h2D;
      6'd13: ch = 8'h3D;  6'd14: ch = 8'h7F;  6'd15: ch = 8'h09;  6'd16: ch = 8'h71;
      6'd17: ch = 8'h77;  6'd18: ch = 8'h65;  6'd19: ch = 8'h72;  6'd20: ch = 8'h74;
      6'd21: ch = 8'h79;  6'd22: ch = 8'h75;  6'd23: ch = 8'h69;  6'd24: ch = 8'h6F;
      6'd25: ch = 8'h70;  6'd26: ch = 8'h5B;  6'd27: ch = 8'h5D;  6'd28: ch = 8'h0D;
      6'd30: ch = 8'h61;  6'd31: ch = 8'h73;  6'd32: ch = 8'h64;  6'd33: ch = 8'h66;
      6'd34: ch = 8'h67;  6'd35: ch = 8'h68;  6'd36: ch = 8'h6A;  6'd37: ch = 8'h6B;
      6'd38: ch = 8'h6C;  6'd39: ch = 8'h3B;  6'd40: ch = 8'h27;  6'd41: ch = 8'h60;
      6'd43: ch = 8'h5C;  6'd44: ch = 8'h7A;  6'd45: ch = 8'h78;  6'd46: ch = 8'h63;
      6'd47: ch = 8'h76;  6'd48: ch = 8'h62;  6'd49: ch = 8'h6E;  6'd50: ch = 8'h6D;
      6'd51: ch = 8'h2C;  6'd52: ch = 8'h2E;  6'd53: ch = 8'h2F;  6'd55: ch = 8'h2A;
      6'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Only entries that differ from the plain table are listed
  function automatic logic [7:0] shifted_map(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd2:  ch = 8'h21;  6'd3:  ch = 8'h40;  6'd4:  ch = 8'h23;  6'd5:  ch = 8'h24;
      6'd6:  ch = 8'h25;  6'd7:  ch = 8'h5E;  6'd8:  ch = 8'h26;  6'd9:  ch = 8'h2A;
      6'd10: ch = 8'h28;  6'd11: ch = 8'h29;  6'd12: ch = 8'h5F;  6'd13: ch = 8'h2B;
      6'd16: ch = 8'h51;  6'd17: ch = 8'h57;  6'd18: ch = 8'h45;  6'd19: ch = 8'h52;
      6'd20: ch = 8'h54;  6'd21: ch = 8'h59;  6'd22: ch = 8'h55;  6'd23: ch = 8'h49;
      6'd24: ch = 8'h4F;  6'd25: ch = 8'h50;  6'd26: ch = 8'h7B;  6'd27: ch = 8'h7D;
      6'd30: ch = 8'h41;  6'd31: ch = 8'h53;  6'd32: ch = 8'h44;  6'd33: ch = 8'h46;
      6'd34: ch = 8'h47;  6'd35: ch = 8'h48;  6'd36: ch = 8'h4A;  6'd37: ch = 8'h4B;
      6'd38: ch = 8'h4C;  6'd39: ch = 8'h3A;  6'd40: ch = 8'h22;  6'd41: ch = 8'h7E;
      6'd43: ch = 8'h7C;  6'd44: ch = 8'h5A;  6'd45: ch = 8'h58;  6'd46: ch = 8'h43;
      6'd47: ch = 8'h56;  6'd48: ch = 8'h42;  6'd49: ch = 8'h4E;  6'd50: ch = 8'h4D;
      6'd51: ch = 8'h3C;  6'd52: ch = 8'h3E;  6'd53: ch = 8'h3F;
      default: ch = plain_map(idx);
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/scs1a_front.sv -----
// Front end: takes scan bytes, tracks prefix and modifier state and turns
// each byte into a queued run of output bytes. Depends on scs1a_pkg.
`default_nettype none

module scs1a_front import scs1a_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] scan_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic extended_pending, extended_pending_next;
  logic shift_held, shift_held_next;
  logic ctrl_held, ctrl_held_next;
  logic alt_held, alt_held_next;

  logic       accept;
  logic       brk;
  logic [6:0] key;
  logic       emit;
  logic [7:0] ch;
  logic [7:0] letter;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign brk      = scan_byte[7];
  assign key      = scan_byte[6:0];
  assign q_push   = accept && emit;

  always_comb begin
    extended_pending_next = extended_pending;
    shift_held_next       = shift_held;
    ctrl_held_next        = ctrl_held;
    alt_held_next         = alt_held;
    emit                  = 1'b0;
    q_cmd                 = '0;
    ch                    = shift_held ? shifted_map(scan_byte[5:0])
                                       : plain_map(scan_byte[5:0]);
    letter                = 8'h00;

    if (scan_byte == SC_EXT_PREFIX) begin
      extended_pending_next = 1'b1;
    end else if (extended_pending) begin
      extended_pending_next = 1'b0;
      if (brk) begin
        if (key == SC_CTRL) ctrl_held_next = 1'b0;
      end else begin
        case (key)
          SC_CTRL:    ctrl_held_next = 1'b1;
          SC_E_UP:    letter = CH_UP;
          SC_E_DOWN:  letter = CH_DOWN;
          SC_E_LEFT:  letter = CH_LEFT;
          SC_E_RIGHT: letter = CH_RIGHT;
          SC_E_HOME:  letter = CH_HOME;
          SC_E_END:   letter = CH_END;
          SC_E_PRTSC: letter = CH_PRTSC;
          default:    letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
          emit      = 1'b1;
          q_cmd.cnt = 2'd3;
          q_cmd.b0  = CH_ESC;
          q_cmd.b1  = CH_LBRACKET;
          q_cmd.b2  = letter;
        end
      end
    end else if (brk) begin
      if (key inside {SC_LSHIFT, SC_RSHIFT}) shift_held_next = 1'b0;
      if (key == SC_CTRL) ctrl_held_next = 1'b0;
      if (key == SC_ALT) alt_held_next = 1'b0;
    end else if (key inside {SC_LSHIFT, SC_RSHIFT}) begin
      shift_held_next = 1'b1;
    end else if (key == SC_CTRL) begin
      ctrl_held_next = 1'b1;
    end else if (key == SC_ALT) begin
      alt_held_next = 1'b1;
    end else if (ctrl_held && key == SC_KEY_D) begin
      emit      = 1'b1;
      q_cmd.cnt = 2'd1;
      q_cmd.b0  = CH_CTRL_D;
    end else if (scan_byte < KEYMAP_LEN && ch != 8'h00) begin
      emit = 1'b1;
      if (ctrl_held) ch = ch & CTRL_MASK;
      // escape prefixes: one for ctrl+shift, one for alt, then the character
      case ({ctrl_held && shift_held, alt_held})
        2'b00: begin
          q_cmd.cnt = 2'd1;
          q_cmd.b0  = ch;
        end
        2'b11: begin
          q_cmd.cnt = 2'd3;
          q_cmd.b0  = CH_ESC;
          q_cmd.b1  = CH_ESC;
          q_cmd.b2  = ch;
        end
        default: begin
          q_cmd.cnt = 2'd2;
          q_cmd.b0  = CH_ESC;
          q_cmd.b1  = ch;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      shift_held       <= 1'b0;
      ctrl_held        <= 1'b0;
      alt_held         <= 1'b0;
    end else if (accept) begin
      extended_pending <= extended_pending_next;
      shift_held       <= shift_held_next;
      ctrl_held        <= ctrl_held_next;
      alt_held         <= alt_held_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scs1a_fifo.sv -----
// Short command queue between front and back end.
// Depends on scs1a_pkg for cmd_t and the depth constants.
`default_nettype none

module scs1a_fifo import scs1a_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full       = (count == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/scs1a_back.sv -----
// Back end: walks each queued run one byte a cycle, while the receiver takes
// them, into the output register and marks the final byte. Depends on scs1a_pkg.
`default_nettype none

module scs1a_back import scs1a_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire cmd_t       head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_byte,
  output logic            last_of_run
);

  logic       busy;
  cmd_t       cur;
  logic [1:0] idx;

  cmd_t       src;
  logic [1:0] src_idx;
  logic       src_valid;
  logic       load;
  logic       src_last;
  logic [7:0] src_byte;

  // Start a run straight from the queue head so single-byte runs need no bubble
  assign src       = busy ? cur : head_cmd;
  assign src_idx   = busy ? idx : 2'd0;
  assign src_valid = busy || head_valid;
  assign load      = src_valid && (!out_valid || out_ready);
  assign src_last  = (src_idx == src.cnt - 2'd1);
  assign pop       = load && !busy;

  always_comb begin
    case (src_idx)
      2'd0:    src_byte = src.b0;
      2'd1:    src_byte = src.b1;
      default: src_byte = src.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        busy      <= !src_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_byte   <= src_byte;
      last_of_run <= src_last;
      cur         <= src;
      idx         <= src_idx + 2'd1;
    end
  end

  a_busy_in_range: assert property (@(posedge clk) disable iff (rst)
                                    busy |-> (idx < cur.cnt))
    else $error("run index past run length");
  a_busy_has_out: assert property (@(posedge clk) disable iff (rst) busy |-> out_valid)
    else $error("run in progress without a byte on the output");
  a_mid_run_not_last: assert property (@(posedge clk) disable iff (rst)
                                       busy |-> !last_of_run)
    else $error("last marker set while run continues");
  a_run_start: assert property (@(posedge clk) disable iff (rst)
                                pop |-> head_cmd.cnt != 2'd0)
    else $error("empty run taken from queue");

endmodule

`default_nettype wire

// ----- rtl/scancode_set1_to_ascii_top.sv -----
// Scan code set 1 to ASCII translator (US layout), top level.
// Depends on scs1a_pkg, scs1a_front, scs1a_fifo and scs1a_back.
`default_nettype none

// Takes one set 1 scan byte per transfer and returns zero to three
// character bytes, last_of_run set on the final one of each run. Cursor
// keys, Home, End and PrintScreen after the E0 prefix give ESC [ letter;
// ctrl masks to a control code, ctrl+shift and alt each prepend ESC, ctrl+D
// gives 0x04. Modifier and prefix bytes only change state. The front end
// takes a scan byte in every cycle while its four-entry run queue has room,
// so input is accepted at one per cycle in bursts; the output register
// sends one byte per cycle while out_ready is high, so a byte that yields
// several characters holds the output until all are sent, and the sustained
// scan byte rate is set by the output port. A run is written into the queue
// and then loaded from its head into the output register.
module scancode_set1_to_ascii_top import scs1a_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] scan_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      char_byte,
  output logic            last_of_run
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  scs1a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .scan_byte (scan_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  scs1a_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  scs1a_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_valid),
    .head_cmd    (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_byte   (char_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ----- verif/tb_scancode_set1_to_ascii_top.sv -----
// Self-checking testbench for scancode_set1_to_ascii_top: directed scan byte table, then
// random key sequences; every character checked against typed rows or an in-bench model.
// Depends on rtl/scs1a_pkg.sv and the translator RTL under rtl/.
module tb_scancode_set1_to_ascii_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scs1a_pkg::*;

  localparam int HOLD_CYCLES  = 64;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_ITEMS = 384;
  localparam int PRESS_ITEMS  = 30;
  localparam int DIR_ROWS     = 26;
  localparam int MAX_REPORTS  = 10;

  // US layout, indexed by make code
  localparam logic [0:57][7:0] US_PLAIN = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h7F, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };
  localparam logic [0:57][7:0] US_SHIFTED = {
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h7F, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  typedef struct packed {
    logic [7:0]      code;
    logic            typed;
    logic [1:0]      n;
    logic [0:2][7:0] chars;
  } scan_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      scan_byte = 8'h00;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [7:0]      char_byte;
  logic            last_of_run;

  // expectation typed into the directed table travels with the scan byte
  logic            row_typed = 1'b0;
  logic [1:0]      row_n = 2'd0;
  logic [0:2][7:0] row_chars = '0;

  // translator state as the bench sees it
  logic ext_seen = 1'b0;
  logic shift_dn = 1'b0;
  logic ctrl_dn  = 1'b0;
  logic alt_dn   = 1'b0;

  char_exp_t expected_chars [$];
  scan_row_t dir_rows [0:DIR_ROWS-1];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  bit        gapless = 1'b0;
  bit        hold_req = 1'b0;
  bit        done = 1'b0;

  scancode_set1_to_ascii_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .scan_byte   (scan_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_byte   (char_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] make_of(input logic [6:0] k);
    return {1'b0, k};
  endfunction

  function automatic logic [7:0] break_of(input logic [6:0] k);
    return {1'b1, k};
  endfunction

  function automatic logic [6:0] pick_nav();
    logic [6:0] k;
    case ($urandom_range(0, 6))
      0: k = SC_E_UP;
      1: k = SC_E_DOWN;
      2: k = SC_E_LEFT;
      3: k = SC_E_RIGHT;
      4: k = SC_E_HOME;
      5: k = SC_E_END;
      default: k = SC_E_PRTSC;
    endcase
    return k;
  endfunction

  // Updates the prefix and modifier state and gives the characters one scan byte yields
  function automatic void predict_chars(input logic [7:0] code, output int n,
                                        output logic [0:2][7:0] run);
    logic [6:0] key;
    logic [7:0] letter;
    logic [7:0] ch;
    key = code[6:0];
    n = 0;
    run = '0;
    letter = 8'h00;
    if (code == SC_EXT_PREFIX) begin
      ext_seen = 1'b1;
      return;
    end
    if (ext_seen) begin
      ext_seen = 1'b0;
      if (code[7]) begin
        if (key == SC_CTRL) ctrl_dn = 1'b0;
        return;
      end
      case (key)
        SC_CTRL:    ctrl_dn = 1'b1;
        SC_E_UP:    letter = CH_UP;
        SC_E_DOWN:  letter = CH_DOWN;
        SC_E_LEFT:  letter = CH_LEFT;
        SC_E_RIGHT: letter = CH_RIGHT;
        SC_E_HOME:  letter = CH_HOME;
        SC_E_END:   letter = CH_END;
        SC_E_PRTSC: letter = CH_PRTSC;
        default:    ;
      endcase
      if (letter != 8'h00) begin
        n = 3;
        run = {CH_ESC, CH_LBRACKET, letter};
      end
      return;
    end
    if (code[7]) begin
      if (key == SC_LSHIFT || key == SC_RSHIFT) shift_dn = 1'b0;
      if (key == SC_CTRL) ctrl_dn = 1'b0;
      if (key == SC_ALT) alt_dn = 1'b0;
      return;
    end
    if (key == SC_LSHIFT || key == SC_RSHIFT) begin
      shift_dn = 1'b1;
    end else if (key == SC_CTRL) begin
      ctrl_dn = 1'b1;
    end else if (key == SC_ALT) begin
      alt_dn = 1'b1;
    end else if (ctrl_dn && key == SC_KEY_D) begin
      n = 1;
      run[0] = CH_CTRL_D;
    end else if (code < KEYMAP_LEN) begin
      ch = shift_dn ? US_SHIFTED[code[5:0]] : US_PLAIN[code[5:0]];
      if (ch != 8'h00) begin
        if (ctrl_dn) ch = ch & CTRL_MASK;
        if (ctrl_dn && shift_dn) begin
          run[n] = CH_ESC;
          n++;
        end
        if (alt_dn) begin
          run[n] = CH_ESC;
          n++;
        end
        run[n] = ch;
        n++;
      end
    end
  endfunction

  function automatic void expect_run(input int n, input logic [0:2][7:0] run);
    for (int i = 0; i < n; i++)
      expected_chars.push_back('{ch: run[i], last: (i == n - 1)});
  endfunction

  function automatic void check_char(input logic [7:0] ch, input logic last);
    char_exp_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected char transfer: %02h last %0d", ch, last);
      return;
    end
    want = expected_chars.pop_front();
    if (ch !== want.ch || last !== want.last) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("char mismatch: expected %02h last %0d, got %02h last %0d",
                 want.ch, want.last, ch, last);
    end
  endfunction

  // Output check first, then prediction for the scan byte taken on this edge
  always @(posedge clk) begin
    int              pn;
    logic [0:2][7:0] prun;
    if (!rst && out_valid && out_ready) check_char(char_byte, last_of_run);
    if (!rst && in_valid && in_ready) begin
      predict_chars(scan_byte, pn, prun);
      if (row_typed) expect_run(row_n, row_chars);
      else expect_run(pn, prun);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (!done) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: stall patterns of random length, plus a long hold-off on request
  initial begin
    int mode;
    int span;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      for (int k = 0; k < span && !hold_req; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= k[0];
        endcase
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_scan(input logic [7:0] code, input logic typed, input logic [1:0] n,
                           input logic [0:2][7:0] chars);
    int gap;
    gap = 0;
    if (!gapless) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    scan_byte <= code;
    row_typed <= typed;
    row_n     <= n;
    row_chars <= chars;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_raw(input logic [7:0] code);
    send_scan(code, 1'b0, 2'd0, '0);
  endtask

  task automatic drain_chars();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One random key event; sent counts every byte sent
  task automatic play_random_event(inout int sent);
    int         pick;
    logic [7:0] k;
    logic [6:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      k = 8'($urandom_range(1, 57));
      send_raw(k);
      sent++;
      if ($urandom_range(0, 1)) begin
        send_raw(break_of(k[6:0]));
        sent++;
      end
    end else if (pick < 55) begin
      case ($urandom_range(0, 3))
        0: m = SC_LSHIFT;
        1: m = SC_RSHIFT;
        2: m = SC_CTRL;
        default: m = SC_ALT;
      endcase
      if ($urandom_range(0, 2) == 0) send_raw(break_of(m));
      else send_raw(make_of(m));
      sent++;
    end else if (pick < 62) begin
      send_raw(make_of(SC_CTRL));
      send_raw(make_of(SC_KEY_D));
      sent += 2;
      if ($urandom_range(0, 1)) begin
        send_raw(break_of(SC_CTRL));
        sent++;
      end
    end else if (pick < 80) begin
      send_raw(SC_EXT_PREFIX);
      case ($urandom_range(0, 5))
        0, 1, 2: send_raw(make_of(pick_nav()));
        3: send_raw(make_of(SC_CTRL));
        4: send_raw(break_of(SC_CTRL));
        default: send_raw(8'($urandom_range(0, 255)));
      endcase
      sent += 2;
    end else if (pick < 85) begin
      // PrintScreen make: filler byte first
      send_raw(SC_EXT_PREFIX);
      send_raw(make_of(SC_LSHIFT));
      send_raw(SC_EXT_PREFIX);
      send_raw(make_of(SC_E_PRTSC));
      sent += 4;
    end else if (pick < 88) begin
      send_raw(SC_EXT_PREFIX);
      send_raw(SC_EXT_PREFIX);
      send_raw(make_of(pick_nav()));
      sent += 3;
    end else begin
      send_raw(8'($urandom_range(0, 255)));
      sent++;
    end
  endtask

  initial begin
    int sent;
    bit pressed;
    bit paused;
    sent = 0;
    pressed = 1'b0;
    paused = 1'b0;

    dir_rows[0]  = '{8'h00, 1'b1, 2'd0, 24'h0};
    dir_rows[1]  = '{8'h02, 1'b1, 2'd1, {8'h31, 16'h0}};
    dir_rows[2]  = '{8'hFF, 1'b1, 2'd0, 24'h0};
    dir_rows[3]  = '{make_of(SC_LSHIFT), 1'b1, 2'd0, 24'h0};
    dir_rows[4]  = '{8'h10, 1'b1, 2'd1, {8'h51, 16'h0}};
    dir_rows[5]  = '{make_of(SC_CTRL), 1'b1, 2'd0, 24'h0};
    dir_rows[6]  = '{8'h1E, 1'b1, 2'd2, {CH_ESC, 8'h01, 8'h00}};
    dir_rows[7]  = '{make_of(SC_KEY_D), 1'b1, 2'd1, {CH_CTRL_D, 16'h0}};
    dir_rows[8]  = '{make_of(SC_ALT), 1'b1, 2'd0, 24'h0};
    dir_rows[9]  = '{8'h1E, 1'b1, 2'd3, {CH_ESC, CH_ESC, 8'h01}};
    dir_rows[10] = '{break_of(SC_LSHIFT), 1'b0, 2'd0, 24'h0};
    dir_rows[11] = '{break_of(SC_CTRL), 1'b0, 2'd0, 24'h0};
    dir_rows[12] = '{8'h39, 1'b1, 2'd2, {CH_ESC, 8'h20, 8'h00}};
    dir_rows[13] = '{break_of(SC_ALT), 1'b0, 2'd0, 24'h0};
    dir_rows[14] = '{SC_EXT_PREFIX, 1'b1, 2'd0, 24'h0};
    dir_rows[15] = '{SC_EXT_PREFIX, 1'b1, 2'd0, 24'h0};
    dir_rows[16] = '{make_of(SC_E_UP), 1'b1, 2'd3, {CH_ESC, CH_LBRACKET, CH_UP}};
    dir_rows[17] = '{SC_EXT_PREFIX, 1'b0, 2'd0, 24'h0};
    dir_rows[18] = '{make_of(SC_CTRL), 1'b0, 2'd0, 24'h0};
    dir_rows[19] = '{make_of(SC_KEY_D), 1'b1, 2'd1, {CH_CTRL_D, 16'h0}};
    dir_rows[20] = '{SC_EXT_PREFIX, 1'b0, 2'd0, 24'h0};
    dir_rows[21] = '{break_of(SC_CTRL), 1'b0, 2'd0, 24'h0};
    dir_rows[22] = '{SC_EXT_PREFIX, 1'b0, 2'd0, 24'h0};
    dir_rows[23] = '{make_of(SC_LSHIFT), 1'b0, 2'd0, 24'h0};
    dir_rows[24] = '{SC_EXT_PREFIX, 1'b0, 2'd0, 24'h0};
    dir_rows[25] = '{make_of(SC_E_PRTSC), 1'b1, 2'd3, {CH_ESC, CH_LBRACKET, CH_PRTSC}};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_scan(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].chars);
    drain_chars();

    while (sent < RANDOM_ITEMS) begin
      if (!pressed && sent >= 150) begin
        // receiver holds off while digit-row keys keep coming, so the run queue fills
        pressed = 1'b1;
        hold_req = 1'b1;
        gapless = 1'b1;
        repeat (PRESS_ITEMS) send_raw(8'($urandom_range(2, 13)));
        sent += PRESS_ITEMS;
        gapless = 1'b0;
      end
      if (!paused && sent >= 300) begin
        paused = 1'b1;
        drain_chars();
      end
      play_random_event(sent);
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    done = 1'b1;
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (expected_chars.size() != 0)
        $display("%0d expected chars never arrived", expected_chars.size());
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- scancode_set1_to_ascii_top.f -----
rtl/scs1a_pkg.sv
rtl/scs1a_front.sv
rtl/scs1a_fifo.sv
rtl/scs1a_back.sv
rtl/scancode_set1_to_ascii_top.sv
verif/tb_scancode_set1_to_ascii_top.sv
